// ----- design/gost_mac_pkg.sv -----
package gost_mac_pkg;

    localparam int ROUNDS        = 16;
    localparam int RND_W         = $clog2(ROUNDS);
    localparam int ROTATE_AMOUNT = 11;
    localparam int SBOX_SET      = 0;
    localparam int HALF_W        = 32;
    localparam int BLOCK_W       = 64;
    localparam int KEY_REGS      = 4;
    localparam int MAC_W         = 32;
    localparam int MAC_BITS_W    = 6;
    localparam int CFG_IDX_W     = 3;

    typedef logic [HALF_W-1:0] half_t;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_01   = 3'd0,
        CFG_KEY_23   = 3'd1,
        CFG_KEY_45   = 3'd2,
        CFG_KEY_67   = 3'd3,
        CFG_MAC_BITS = 3'd4
    } cfg_idx_t;

    localparam logic [MAC_BITS_W-1:0] MAC_BITS_RESET = 6'd32;

    // Box 0 works on the top nibble of the word
    localparam logic [3:0] SBOX [0:1][0:7][0:15] = '{
        '{
            '{4'd1, 4'd15, 4'd13, 4'd0, 4'd5, 4'd7, 4'd10, 4'd4,
              4'd9, 4'd2, 4'd3, 4'd14, 4'd6, 4'd11, 4'd8, 4'd12},
            '{4'd13, 4'd11, 4'd4, 4'd1, 4'd3, 4'd15, 4'd5, 4'd9,
              4'd0, 4'd10, 4'd14, 4'd7, 4'd6, 4'd8, 4'd2, 4'd12},
            '{4'd4, 4'd11, 4'd10, 4'd0, 4'd7, 4'd2, 4'd1, 4'd13,
              4'd3, 4'd6, 4'd8, 4'd5, 4'd9, 4'd12, 4'd15, 4'd14},
            '{4'd6, 4'd12, 4'd7, 4'd1, 4'd5, 4'd15, 4'd13, 4'd8,
              4'd4, 4'd10, 4'd9, 4'd14, 4'd0, 4'd3, 4'd11, 4'd2},
            '{4'd7, 4'd13, 4'd10, 4'd1, 4'd0, 4'd8, 4'd9, 4'd15,
              4'd14, 4'd4, 4'd6, 4'd12, 4'd11, 4'd2, 4'd5, 4'd3},
            '{4'd5, 4'd8, 4'd1, 4'd13, 4'd10, 4'd3, 4'd4, 4'd2,
              4'd14, 4'd15, 4'd12, 4'd7, 4'd6, 4'd0, 4'd9, 4'd11},
            '{4'd14, 4'd11, 4'd4, 4'd12, 4'd6, 4'd13, 4'd15, 4'd10,
              4'd2, 4'd3, 4'd8, 4'd1, 4'd0, 4'd7, 4'd5, 4'd9},
            '{4'd4, 4'd10, 4'd9, 4'd2, 4'd13, 4'd8, 4'd0, 4'd14,
              4'd6, 4'd11, 4'd1, 4'd12, 4'd7, 4'd15, 4'd5, 4'd3}
        },
        '{
            '{4'd1, 4'd7, 4'd14, 4'd13, 4'd0, 4'd5, 4'd8, 4'd3,
              4'd4, 4'd15, 4'd10, 4'd6, 4'd9, 4'd12, 4'd11, 4'd2},
            '{4'd8, 4'd14, 4'd2, 4'd5, 4'd6, 4'd9, 4'd1, 4'd12,
              4'd15, 4'd4, 4'd11, 4'd0, 4'd13, 4'd10, 4'd3, 4'd7},
            '{4'd5, 4'd13, 4'd15, 4'd6, 4'd9, 4'd2, 4'd12, 4'd10,
              4'd11, 4'd7, 4'd8, 4'd1, 4'd4, 4'd3, 4'd14, 4'd0},
            '{4'd7, 4'd15, 4'd5, 4'd10, 4'd8, 4'd1, 4'd6, 4'd13,
              4'd0, 4'd9, 4'd3, 4'd14, 4'd11, 4'd4, 4'd2, 4'd12},
            '{4'd12, 4'd8, 4'd2, 4'd1, 4'd13, 4'd4, 4'd15, 4'd6,
              4'd7, 4'd0, 4'd10, 4'd5, 4'd3, 4'd14, 4'd9, 4'd11},
            '{4'd11, 4'd3, 4'd5, 4'd8, 4'd2, 4'd15, 4'd10, 4'd13,
              4'd14, 4'd1, 4'd7, 4'd4, 4'd12, 4'd9, 4'd6, 4'd0},
            '{4'd6, 4'd8, 4'd2, 4'd3, 4'd9, 4'd10, 4'd5, 4'd12,
              4'd1, 4'd14, 4'd4, 4'd7, 4'd11, 4'd13, 4'd0, 4'd15},
            '{4'd12, 4'd4, 4'd6, 4'd2, 4'd10, 4'd5, 4'd11, 4'd9,
              4'd14, 4'd8, 4'd13, 4'd7, 4'd0, 4'd3, 4'd15, 4'd1}
        }
    };

endpackage

// ----- design/gost_block_cipher_mac.sv -----
// GOST 28147-89 MAC engine.
// Input stream: one message byte per transaction on s_tdata[7:0]; s_tlast
// marks the final byte of a message. Output stream: one 32-bit MAC per
// message on m_tdata, low mac_bits bits valid, upper bits zero.
// Configuration: cfg_we/cfg_index/cfg_data write the four 64-bit key
// registers (index 0..3) and mac_bits (index 4); other indexes are ignored.
// Flow: a byte that does not complete a block leaves s_tready high. A byte
// that completes a block (eighth byte or last byte) starts 16 Feistel
// rounds on the shared round unit, one round per cycle, with s_tready low
// during the rounds and, for a last byte, in the finish state after them.
// For a last byte the MAC is registered in that finish state, which also
// raises m_tvalid.
// The output register lets the next message start while a MAC waits; if a
// new MAC is ready while the old one is still not taken, the engine holds
// in its finish state with s_tready low until m_tready.
// Reset: chain value and byte position clear, keys clear, mac_bits = 32.
module gost_block_cipher_mac (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    input  logic [7:0]                                s_tdata,   // [7:0] data_byte
    input  logic                                      s_tlast,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [gost_mac_pkg::MAC_W-1:0]            m_tdata,   // [31:0] mac
    input  logic                                      cfg_we,
    input  logic [gost_mac_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [gost_mac_pkg::BLOCK_W-1:0]          cfg_data
);
    import gost_mac_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FINISH
    } state_t;

    state_t                  state_reg;
    logic [BLOCK_W-1:0]      key_reg [KEY_REGS];
    logic [MAC_BITS_W-1:0]   mac_bits_reg;
    half_t                   a_reg;
    half_t                   b_reg;
    logic [BLOCK_W-1:0]      asm_reg;
    logic [2:0]              pos_reg;
    logic [RND_W-1:0]        rnd_reg;
    logic                    last_reg;

    logic [BLOCK_W-1:0]      asm_next;
    logic [BLOCK_W-1:0]      key_sel;
    half_t                   key_word;
    half_t                   na;
    half_t                   mac_mask;
    logic                    s_acc;
    logic                    out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_tvalid || m_tready;

    // shift of 32 or more yields zero, so the mask saturates at 32 bits
    assign mac_mask = ~(32'hFFFF_FFFF << mac_bits_reg);

    always_comb
    begin
        asm_next = asm_reg;
        asm_next[{~pos_reg, 3'b000} +: 8] = s_tdata;
    end

    // round r uses key word r mod 8
    assign key_sel  = key_reg[rnd_reg[2:1]];
    assign key_word = rnd_reg[0] ? key_sel[BLOCK_W-1:HALF_W] : key_sel[HALF_W-1:0];

    gost_mac_round u_round (
        .a   (a_reg),
        .b   (b_reg),
        .key (key_word),
        .na  (na)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_REGS; i++)
            begin
                key_reg[i] <= '0;
            end
            mac_bits_reg <= MAC_BITS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_01, CFG_KEY_23, CFG_KEY_45, CFG_KEY_67:
                    key_reg[cfg_index[1:0]] <= cfg_data;
                CFG_MAC_BITS:
                    mac_bits_reg <= cfg_data[MAC_BITS_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            a_reg     <= '0;
            b_reg     <= '0;
            asm_reg   <= '0;
            pos_reg   <= '0;
            rnd_reg   <= '0;
            last_reg  <= 1'b0;
            m_tvalid  <= 1'b0;
            m_tdata   <= '0;
        end
        else
        begin
            // in the finish state the output register is reloaded below
            if (m_tvalid && m_tready && state_reg != ST_FINISH)
            begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_acc)
                    begin
                        if (pos_reg == 3'd7 || s_tlast)
                        begin
                            a_reg     <= a_reg ^ asm_next[BLOCK_W-1:HALF_W];
                            b_reg     <= b_reg ^ asm_next[HALF_W-1:0];
                            asm_reg   <= '0;
                            pos_reg   <= '0;
                            rnd_reg   <= '0;
                            last_reg  <= s_tlast;
                            state_reg <= ST_ROUND;
                        end
                        else
                        begin
                            asm_reg <= asm_next;
                            pos_reg <= pos_reg + 3'd1;
                        end
                    end
                end
                ST_ROUND:
                begin
                    a_reg   <= na;
                    b_reg   <= a_reg;
                    rnd_reg <= rnd_reg + RND_W'(1);
                    if (rnd_reg == RND_W'(ROUNDS - 1))
                    begin
                        state_reg <= last_reg ? ST_FINISH : ST_IDLE;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        m_tdata   <= a_reg & mac_mask;
                        m_tvalid  <= 1'b1;
                        a_reg     <= '0;
                        b_reg     <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> !s_tready)
        else $error("input accepted during rounds");

    a_idle_rnd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (rnd_reg == '0))
        else $error("round counter not back at zero");

    a_mac_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_FINISH))
        else $error("MAC issued outside finish state");

    a_mac_masked: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata & ~mac_mask) == '0))
        else $error("MAC bits above mac_bits not zero");
`endif

endmodule

// ----- design/gost_mac_round.sv -----
module gost_mac_round (
    input  gost_mac_pkg::half_t a,
    input  gost_mac_pkg::half_t b,
    input  gost_mac_pkg::half_t key,
    output gost_mac_pkg::half_t na
);
    import gost_mac_pkg::*;

    localparam int SET = SBOX_SET & 1;
    localparam int ROT = ROTATE_AMOUNT & 31;

    half_t sum;
    half_t sub;
    half_t rot;

    assign sum = a + key;

    always_comb
    begin
        sub = '0;
        for (int n = 0; n < 8; n++)
        begin
            sub[28 - 4*n +: 4] = SBOX[SET][n][sum[28 - 4*n +: 4]];
        end
    end

    generate
        if (ROT == 0)
        begin : g_norot
            assign rot = sub;
        end
        else
        begin : g_rot
            assign rot = {sub[HALF_W-1-ROT:0], sub[HALF_W-1:HALF_W-ROT]};
        end
    endgenerate

    assign na = b ^ rot;

endmodule

// ----- tb/sv/gost_block_cipher_mac_tb.sv -----
module gost_block_cipher_mac_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gost_mac_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASES      = 10;
    localparam int PHASE_BYTES = 153;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 20;

    // Same S-box contents as the standard test set and the tc26 Z set,
    // box 0 on the top nibble
    localparam bit [3:0] SUBST [2][8][16] = '{
        '{
            '{1, 15, 13, 0, 5, 7, 10, 4, 9, 2, 3, 14, 6, 11, 8, 12},
            '{13, 11, 4, 1, 3, 15, 5, 9, 0, 10, 14, 7, 6, 8, 2, 12},
            '{4, 11, 10, 0, 7, 2, 1, 13, 3, 6, 8, 5, 9, 12, 15, 14},
            '{6, 12, 7, 1, 5, 15, 13, 8, 4, 10, 9, 14, 0, 3, 11, 2},
            '{7, 13, 10, 1, 0, 8, 9, 15, 14, 4, 6, 12, 11, 2, 5, 3},
            '{5, 8, 1, 13, 10, 3, 4, 2, 14, 15, 12, 7, 6, 0, 9, 11},
            '{14, 11, 4, 12, 6, 13, 15, 10, 2, 3, 8, 1, 0, 7, 5, 9},
            '{4, 10, 9, 2, 13, 8, 0, 14, 6, 11, 1, 12, 7, 15, 5, 3}
        },
        '{
            '{1, 7, 14, 13, 0, 5, 8, 3, 4, 15, 10, 6, 9, 12, 11, 2},
            '{8, 14, 2, 5, 6, 9, 1, 12, 15, 4, 11, 0, 13, 10, 3, 7},
            '{5, 13, 15, 6, 9, 2, 12, 10, 11, 7, 8, 1, 4, 3, 14, 0},
            '{7, 15, 5, 10, 8, 1, 6, 13, 0, 9, 3, 14, 11, 4, 2, 12},
            '{12, 8, 2, 1, 13, 4, 15, 6, 7, 0, 10, 5, 3, 14, 9, 11},
            '{11, 3, 5, 8, 2, 15, 10, 13, 14, 1, 7, 4, 12, 9, 6, 0},
            '{6, 8, 2, 3, 9, 10, 5, 12, 1, 14, 4, 7, 11, 13, 0, 15},
            '{12, 4, 6, 2, 10, 5, 11, 9, 14, 8, 13, 7, 0, 3, 15, 1}
        }
    };

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } msg_byte_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [7:0] data_byte
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [MAC_W-1:0]      m_tdata;          // [31:0] mac
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_KEY_01;
    logic [BLOCK_W-1:0]    cfg_data  = '0;

    // Model state
    logic [BLOCK_W-1:0]    key_q [KEY_REGS];
    logic [MAC_BITS_W-1:0] mac_bits_q;
    logic [BLOCK_W-1:0]    chain;
    logic [BLOCK_W-1:0]    gathered;
    logic [2:0]            fill_pos;

    msg_byte_t             bytes_to_send [$];
    logic [MAC_W-1:0]      macs_due [$];
    bit                    byte_taken = 1'b0;
    bit                    calm       = 1'b0;
    int                    hold_left  = 0;
    int                    mismatches = 0;
    int                    cycle_count = 0;

    gost_block_cipher_mac u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [31:0] gost_round(logic [31:0] a, logic [31:0] k);
        logic [31:0] sum;
        logic [31:0] sub;
        int          rot;
        sum = a + k;
        sub = '0;
        rot = ROTATE_AMOUNT % 32;
        for (int n = 0; n < 8; n++)
        begin
            sub[28 - 4 * n +: 4] = SUBST[SBOX_SET & 1][n][sum[28 - 4 * n +: 4]];
        end
        if (rot == 0)
            return sub;
        return (sub << rot) | (sub >> (32 - rot));
    endfunction

    function automatic logic [63:0] gost_encrypt(logic [63:0] v);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] na;
        logic [63:0] kreg;
        a = v[63:32];
        b = v[31:0];
        for (int r = 0; r < ROUNDS; r++)
        begin
            kreg = key_q[(r % 8) >> 1];
            na = b ^ gost_round(a, (r % 2) ? kreg[63:32] : kreg[31:0]);
            b = a;
            a = na;
        end
        return {a, b};
    endfunction

    // Packs one accepted byte; a last byte closes the message and queues its MAC
    function automatic void absorb_msg_byte(logic [7:0] b, logic last);
        int          at;
        int          keep;
        logic [31:0] mask;
        at = int'(fill_pos);
        gathered = gathered | ({56'd0, b} << (56 - 8 * at));
        fill_pos = fill_pos + 3'd1;
        if (at == 7 || last)
        begin
            chain    = gost_encrypt(chain ^ gathered);
            gathered = '0;
            fill_pos = '0;
        end
        if (last)
        begin
            keep = (mac_bits_q > 32) ? 32 : int'(mac_bits_q);
            mask = (keep >= 32) ? 32'hFFFF_FFFF : ((32'd1 << keep) - 32'd1);
            macs_due.push_back(chain[63:32] & mask);
            chain = '0;
        end
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [63:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx <= CFG_KEY_67)
            key_q[int'(idx)] = value;
        else if (idx == CFG_MAC_BITS)
            mac_bits_q = value[MAC_BITS_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_byte(logic [7:0] b, logic last);
        msg_byte_t t;
        t.data = b;
        t.last = last;
        bytes_to_send.push_back(t);
    endtask

    task automatic queue_messages(int total, int longest);
        int         sent;
        int         len;
        logic [7:0] b;
        sent = 0;
        while (sent < total)
        begin
            case ($urandom_range(9))
                0:       len = 1;
                1, 2:    len = 8 * $urandom_range(1, 3);
                default: len = $urandom_range(1, longest);
            endcase
            for (int i = 0; i < len; i++)
            begin
                case ($urandom_range(9))
                    0:       b = 8'h00;
                    1:       b = 8'hFF;
                    default: b = 8'($urandom);
                endcase
                push_byte(b, i == len - 1);
            end
            sent += len;
        end
    endtask

    // Block is idle once the last MAC is out; every phase ends on a last byte
    task automatic wait_drained();
        while (bytes_to_send.size() != 0 || s_tvalid || macs_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Driver: next byte goes out only after the current one was taken
    always @(negedge clk)
    begin
        msg_byte_t nxt;
        if (rst_n && !(s_tvalid && !byte_taken))
        begin
            if (bytes_to_send.size() != 0 && (calm || $urandom_range(99) >= 23))
            begin
                nxt = bytes_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.data;
                s_tlast  <= nxt.last;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver, with its own hold-off counter
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            m_tready <= calm || ($urandom_range(99) >= 23);
    end

    // Monitor: predict on each input transaction, check each output transaction
    always @(posedge clk)
    begin
        cycle_count++;
        byte_taken = rst_n && s_tvalid && s_tready;
        if (byte_taken)
            absorb_msg_byte(s_tdata, s_tlast);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (macs_due.size() == 0)
            begin
                $error("mac: expected none, got %h", m_tdata);
                mismatches++;
            end
            else
            begin
                if (m_tdata !== macs_due[0])
                begin
                    $error("mac: expected %h, got %h", macs_due[0], m_tdata);
                    mismatches++;
                end
                void'(macs_due.pop_front());
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("gost_block_cipher_mac: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] key_val;
        int          width;
        for (int i = 0; i < KEY_REGS; i++)
            key_q[i] = '0;
        mac_bits_q = MAC_BITS_RESET;
        chain      = '0;
        gathered   = '0;
        fill_pos   = '0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset keys and width, single-byte messages, bit walk,
        // a full block, a block plus a zero byte, a short partial block
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        for (int i = 0; i < 8; i++)
            push_byte(8'd1 << i, i == 7);
        for (int i = 0; i < 9; i++)
            push_byte((i < 8) ? 8'hFF : 8'h00, i == 8);
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b1);
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            for (int i = 0; i < KEY_REGS; i++)
            begin
                key_val = (p == 0) ? '1 : (p == 2) ? '0 : {$urandom, $urandom};
                write_reg(cfg_idx_t'(CFG_KEY_01 + i), key_val);
            end
            // zero width gives a zero MAC, anything above 32 saturates
            case (p)
                0:       width = 32;
                1:       width = 1;
                2:       width = 0;
                3:       width = 33;
                4:       width = 63;
                5:       width = 16;
                6:       width = 31;
                7:       width = 2;
                default: width = $urandom_range(1, 32);
            endcase
            write_reg(CFG_MAC_BITS, 64'(width));
            // unmapped indexes must leave everything alone
            if (p == 4)
                for (int i = 1; i < 4; i++)
                    write_reg(cfg_idx_t'(CFG_MAC_BITS + i), {$urandom, $urandom});

            calm = (p == 6);
            if (p == 3)
            begin
                // short messages pile up behind a stalled output
                queue_messages(PHASE_BYTES, 3);
                hold_left = HOLD_CYCLES;
            end
            else
                queue_messages(PHASE_BYTES, 20);
            wait_drained();
        end

        repeat (2 * SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("gost_block_cipher_mac: match");
        else
            $display("gost_block_cipher_mac: mismatch");
        $finish;
    end

endmodule
